>>> src/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg
// Shared widths, fixed-point constants and saturation helpers for the
// distribution mean and deviation block.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XW        = 24;
    localparam int AW        = 128;
    localparam int MPW       = 64;
    localparam int DVW       = 72;
    localparam int DCW       = $clog2(DVW + 1);

    localparam logic [3:0] DIV_FIRST  = 4'd6;
    localparam logic [3:0] DIV_SECOND = 4'd12;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    function automatic logic signed [63:0] term_sat(input logic [DVW-1:0] mag,
                                                   input logic neg);
        logic [63:0] m;
        begin
            m = (mag > DVW'(S64_MAX)) ? S64_MAX : mag[63:0];
            return neg ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? S64_MIN : S64_MAX;
            return s[63:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> src/dms_point_if.sv
// ----------------------------------------------------------------------------
// dms_point_if
// Point channel: one distribution point per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dms_point_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] x_value;
    logic        [23:0] weight;
    logic               last_point;

    modport source (output valid, x_value, weight, last_point, input ready);
    modport sink   (input valid, x_value, weight, last_point, output ready);
endinterface

`default_nettype wire

>>> src/dms_result_if.sv
// ----------------------------------------------------------------------------
// dms_result_if
// Result channel: mean, deviation and error flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dms_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] mean_out;
    logic        [23:0] deviation_out;
    logic               error_flag;

    modport source (output valid, mean_out, deviation_out, error_flag, input ready);
    modport sink   (input valid, mean_out, deviation_out, error_flag, output ready);
endinterface

`default_nettype wire

>>> src/distribution_mean_stdev.sv
// ----------------------------------------------------------------------------
// distribution_mean_stdev
// Mean and standard deviation from the first and second moments.
// ----------------------------------------------------------------------------
// One point is taken at a time; all arithmetic runs on a single shift-add
// multiplier (one multiplier bit per cycle, ends early when the remaining
// multiplier bits are zero), a radix-2 constant divider and a bit-pair square
// root. A continuous segment uses the divider twice; a continuous point with
// no segment yet goes straight to the post step. The result of the last point
// waits while the previous result still waits in the output register.
// Ready is high only while the sequencer is idle.
`default_nettype none

module distribution_mean_stdev
    import dms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    dms_point_if.sink  pt,
    dms_result_if.source res
);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_DIV, S_SQRT,
        S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10, S_C11, S_C12,
        S_D1, S_D2, S_D3, S_POST, S_F1, S_FIN
    } state_t;

    state_t              state_reg, ret_reg;
    logic                mode_reg;
    logic signed [63:0]  first_reg, second_reg;
    logic signed [XW-1:0] x0_reg, x1_reg;
    logic [XW-1:0]       y0_reg, y1_reg;
    logic                have_reg, err_reg, last_reg;
    logic [AW-1:0]       acc_reg, mc_reg;
    logic [MPW-1:0]      mp_reg;
    logic                sub_reg, neg_reg;
    logic [DVW-1:0]      dv_reg;
    logic [3:0]          rem_reg, dsor_reg;
    logic [DCW-1:0]      dcnt_reg;
    logic [63:0]         n_reg, r_reg, bit_reg;
    logic [47:0]         p00_reg, p11_reg;
    logic signed [48:0]  p01_reg;
    logic signed [23:0]  mean_reg;
    logic [23:0]         dev_reg;
    logic                ferr_reg;
    logic                out_valid_reg;
    logic signed [23:0]  out_mean_reg;
    logic [23:0]         out_dev_reg;
    logic                out_err_reg;

    logic signed [24:0]  dx;
    logic [24:0]         adx;
    logic signed [25:0]  s2a, s2b;
    logic [25:0]         as2a, as2b;
    logic [23:0]         ax0, ax1, ax_in;
    logic signed [24:0]  dx_in;
    logic [AW-1:0]       aacc;
    logic signed [52:0]  q0, q1;
    logic [4:0]          trial;
    logic [63:0]         rb;
    logic [63:0]         mmag, mq;
    logic [95:0]         sq;

    always_comb
    begin
        dx    = {x1_reg[23], x1_reg} - {x0_reg[23], x0_reg};
        adx   = dx[24] ? 25'(-dx) : 25'(dx);
        s2a   = ({{2{x0_reg[23]}}, x0_reg} <<< 1) + {{2{x1_reg[23]}}, x1_reg};
        s2b   = {{2{x0_reg[23]}}, x0_reg} + ({{2{x1_reg[23]}}, x1_reg} <<< 1);
        as2a  = s2a[25] ? 26'(-s2a) : 26'(s2a);
        as2b  = s2b[25] ? 26'(-s2b) : 26'(s2b);
        ax0   = x0_reg[23] ? 24'(-x0_reg) : 24'(x0_reg);
        ax1   = x1_reg[23] ? 24'(-x1_reg) : 24'(x1_reg);
        ax_in = pt.x_value[23] ? 24'(-pt.x_value) : 24'(pt.x_value);
        dx_in = {pt.x_value[23], pt.x_value} - {x0_reg[23], x0_reg};
        aacc  = acc_reg[AW-1] ? -acc_reg : acc_reg;
        q0    = 53'(3 * $signed({5'd0, p00_reg})) + 53'(2 * p01_reg)
              + $signed({5'd0, p11_reg});
        q1    = $signed({5'd0, p00_reg}) + 53'(2 * p01_reg)
              + 53'(3 * $signed({5'd0, p11_reg}));
        trial = {rem_reg, dv_reg[DVW-1]};
        rb    = r_reg + bit_reg;
        mmag  = first_reg[63] ? 64'(-first_reg) : 64'(first_reg);
        mq    = mmag >> FRAC_BITS;
        sq    = acc_reg[2*FRAC_BITS +: 96];
    end

    assign pt.ready          = (state_reg == S_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.mean_out      = out_mean_reg;
    assign res.deviation_out = out_dev_reg;
    assign res.error_flag    = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            mode_reg      <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            x0_reg        <= '0;
            y0_reg        <= '0;
            have_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (res.valid && res.ready && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pt.valid)
                    begin
                        x1_reg   <= pt.x_value;
                        y1_reg   <= pt.weight;
                        last_reg <= pt.last_point;
                        acc_reg  <= '0;
                        if (!mode_reg)
                        begin
                            mc_reg    <= AW'(ax_in);
                            mp_reg    <= MPW'(pt.weight);
                            sub_reg   <= pt.x_value[23];
                            ret_reg   <= S_D1;
                            state_reg <= S_MUL;
                        end
                        else if (!have_reg)
                            state_reg <= S_POST;
                        else if (dx_in == '0)
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= S_POST;
                        end
                        else
                            state_reg <= S_C1;
                    end
                end
                S_MUL:
                begin
                    if (mp_reg == '0)
                        state_reg <= ret_reg;
                    else
                    begin
                        if (mp_reg[0])
                            acc_reg <= sub_reg ? acc_reg - mc_reg : acc_reg + mc_reg;
                        mc_reg <= mc_reg << 1;
                        mp_reg <= mp_reg >> 1;
                    end
                end
                S_DIV:
                begin
                    if (trial >= {1'b0, dsor_reg})
                    begin
                        rem_reg <= 4'(trial - {1'b0, dsor_reg});
                        dv_reg  <= {dv_reg[DVW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[3:0];
                        dv_reg  <= {dv_reg[DVW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DCW'(1))
                        state_reg <= ret_reg;
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        dev_reg   <= (r_reg > 64'hFF_FFFF) ? 24'hFF_FFFF : r_reg[23:0];
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        if (n_reg >= rb)
                        begin
                            n_reg <= n_reg - rb;
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end
                        else
                            r_reg <= r_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_C1:
                begin
                    mc_reg    <= AW'(y0_reg);
                    mp_reg    <= MPW'(as2a);
                    sub_reg   <= s2a[25];
                    ret_reg   <= S_C2;
                    state_reg <= S_MUL;
                end
                S_C2:
                begin
                    mc_reg    <= AW'(y1_reg);
                    mp_reg    <= MPW'(as2b);
                    sub_reg   <= s2b[25];
                    ret_reg   <= S_C3;
                    state_reg <= S_MUL;
                end
                S_C3:
                begin
                    neg_reg   <= acc_reg[AW-1] ^ dx[24];
                    mc_reg    <= aacc;
                    mp_reg    <= MPW'(adx);
                    sub_reg   <= 1'b0;
                    acc_reg   <= '0;
                    ret_reg   <= S_C4;
                    state_reg <= S_MUL;
                end
                S_C4:
                begin
                    dv_reg    <= acc_reg[FRAC_BITS +: DVW];
                    rem_reg   <= '0;
                    dsor_reg  <= DIV_FIRST;
                    dcnt_reg  <= DCW'(DVW);
                    ret_reg   <= S_C5;
                    state_reg <= S_DIV;
                end
                S_C5:
                begin
                    first_reg <= acc_add(first_reg, term_sat(dv_reg, neg_reg));
                    acc_reg   <= '0;
                    mc_reg    <= AW'(ax0);
                    mp_reg    <= MPW'(ax0);
                    sub_reg   <= 1'b0;
                    ret_reg   <= S_C6;
                    state_reg <= S_MUL;
                end
                S_C6:
                begin
                    p00_reg   <= acc_reg[47:0];
                    acc_reg   <= '0;
                    mc_reg    <= AW'(ax0);
                    mp_reg    <= MPW'(ax1);
                    sub_reg   <= x0_reg[23] ^ x1_reg[23];
                    ret_reg   <= S_C7;
                    state_reg <= S_MUL;
                end
                S_C7:
                begin
                    p01_reg   <= acc_reg[48:0];
                    acc_reg   <= '0;
                    mc_reg    <= AW'(ax1);
                    mp_reg    <= MPW'(ax1);
                    sub_reg   <= 1'b0;
                    ret_reg   <= S_C8;
                    state_reg <= S_MUL;
                end
                S_C8:
                begin
                    p11_reg   <= acc_reg[47:0];
                    acc_reg   <= '0;
                    state_reg <= S_C9;
                end
                S_C9:
                begin
                    // q0 and q1 are never negative
                    mc_reg    <= AW'(q0[51:0]);
                    mp_reg    <= MPW'(y0_reg);
                    sub_reg   <= 1'b0;
                    ret_reg   <= S_C10;
                    state_reg <= S_MUL;
                end
                S_C10:
                begin
                    mc_reg    <= AW'(q1[51:0]);
                    mp_reg    <= MPW'(y1_reg);
                    ret_reg   <= S_C11;
                    state_reg <= S_MUL;
                end
                S_C11:
                begin
                    mc_reg    <= acc_reg;
                    mp_reg    <= MPW'(adx);
                    acc_reg   <= '0;
                    ret_reg   <= S_C12;
                    state_reg <= S_MUL;
                end
                S_C12:
                begin
                    dv_reg    <= acc_reg[2*FRAC_BITS +: DVW];
                    rem_reg   <= '0;
                    dsor_reg  <= DIV_SECOND;
                    dcnt_reg  <= DCW'(DVW);
                    ret_reg   <= S_POST;
                    state_reg <= S_DIV;
                end
                S_D1:
                begin
                    first_reg <= acc_add(first_reg, acc_reg[63:0]);
                    acc_reg   <= '0;
                    mc_reg    <= AW'(ax1);
                    mp_reg    <= MPW'(ax1);
                    sub_reg   <= 1'b0;
                    ret_reg   <= S_D2;
                    state_reg <= S_MUL;
                end
                S_D2:
                begin
                    mc_reg    <= acc_reg;
                    mp_reg    <= MPW'(y1_reg);
                    acc_reg   <= '0;
                    ret_reg   <= S_D3;
                    state_reg <= S_MUL;
                end
                S_D3:
                begin
                    second_reg <= acc_add(second_reg, acc_reg[FRAC_BITS +: 64]);
                    state_reg  <= S_POST;
                end
                S_POST:
                begin
                    // continuous second-moment term lands here from the divider
                    if (mode_reg && have_reg && dx != '0)
                        second_reg <= acc_add(second_reg, term_sat(dv_reg, dx[24]));
                    x0_reg   <= x1_reg;
                    y0_reg   <= y1_reg;
                    have_reg <= 1'b1;
                    if (!last_reg)
                        state_reg <= S_IDLE;
                    else
                    begin
                        if (first_reg[63])
                            mean_reg <= (mq > 64'h80_0000) ? 24'sh80_0000 : 24'(-mq);
                        else
                            mean_reg <= (mq > 64'h7F_FFFF) ? 24'sh7F_FFFF : 24'(mq);
                        acc_reg   <= '0;
                        mc_reg    <= AW'(mmag);
                        mp_reg    <= mmag;
                        sub_reg   <= 1'b0;
                        ret_reg   <= S_F1;
                        state_reg <= S_MUL;
                    end
                end
                S_F1:
                begin
                    if (second_reg[63] || sq[95:64] != '0 || sq[63:0] > 64'(second_reg))
                    begin
                        dev_reg   <= '0;
                        ferr_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        ferr_reg  <= err_reg;
                        n_reg     <= 64'(second_reg) - sq[63:0];
                        r_reg     <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= S_SQRT;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_mean_reg  <= mean_reg;
                        out_dev_reg   <= dev_reg;
                        out_err_reg   <= ferr_reg;
                        first_reg     <= '0;
                        second_reg    <= '0;
                        have_reg      <= 1'b0;
                        err_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
